FILE: design/dss_pkg.sv
// Shared constants and types for the drum step sequencer.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int NUM_VOICES = 12;
    localparam int NUM_STEPS  = 16;
    localparam int STEP_W     = $clog2(NUM_STEPS);
    localparam int VOICE_W    = 4;

    // Dividend and quotient width of the shared divider, and remainder width.
    localparam int DIV_W = 41;
    localparam int REM_W = 32;

    localparam int SR_W = 18;
    localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

    // 1500 * 4096 = 375 * 2^14: ticks per step numerator factor.
    localparam int TICK_MULT_W = 9;
    localparam logic [TICK_MULT_W-1:0] TICK_MULT = 9'd375;
    localparam int TICK_SHIFT = 14;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_RESET   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
        logic             load;
    } t_div_req;

    typedef struct packed {
        logic [DIV_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
        logic             done;
    } t_div_rsp;

endpackage

FILE: design/dss_div.sv
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module dss_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dss_pkg::t_div_req i_req,
    output dss_pkg::t_div_rsp o_rsp
);

    logic [dss_pkg::DIV_W-1:0] r_quo;
    logic [dss_pkg::REM_W-1:0] r_rem;
    logic [dss_pkg::REM_W-1:0] r_dvs;
    logic [5:0]                r_cnt;
    logic                      r_run;
    logic                      r_done;

    logic [dss_pkg::REM_W:0]   shifted;
    logic [dss_pkg::REM_W+1:0] diff;
    logic                      fits;

    assign shifted = {r_rem, r_quo[dss_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign fits    = ~diff[dss_pkg::REM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.load && r_run && (r_cnt == 6'd1);
            if (i_req.load) begin
                r_run <= 1'b1;
                r_cnt <= 6'(dss_pkg::DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[dss_pkg::DIV_W-2:0], fits};
            // remainder stays below the divisor, so 32 bits hold it
            r_rem <= fits ? diff[dss_pkg::REM_W-1:0] : shifted[dss_pkg::REM_W-1:0];
        end
    end

    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;
    assign o_rsp.done      = r_done;

endmodule

FILE: design/drum_step_sequencer.sv
// Top level of the 16-step drum trigger sequencer.
//
//  port group      dir  handshake                     content
//  command         in   i_start while o_busy low       opcode and operands
//  result          out  o_valid, one cycle, no stall   triggers, step, cell
//  sample_rate     in   i_cfg_we, no wait              i_cfg_data
//
// Write, read, reset playback, stopped transport and host-locked advance return
// their word in the cycle after acceptance. An internal-clock advance holds o_busy
// high through the multiply, two divider waits (step period, then steps passed)
// and a walk over the steps passed, at most 16, and returns its word as the
// walk ends and o_busy falls.
// Reset clears the grid and playback state and restores sample_rate to 48000.
// Results cannot be stalled.
`timescale 1ns / 1ps

module drum_step_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_opcode,
    input  logic                         i_transport_playing,
    input  logic                         i_use_host_position,
    input  logic [47:0]                  i_host_position,
    input  logic [12:0]                  i_block_samples,
    input  logic [16:0]                  i_tempo_centibpm,
    input  logic [3:0]                   i_voice,
    input  logic [3:0]                   i_step_index,
    input  logic                         i_cell_on,
    input  logic                         i_cfg_we,
    input  logic [dss_pkg::SR_W-1:0]     i_cfg_data,
    output logic                         o_valid,
    output logic [11:0]                  o_triggers,
    output logic [3:0]                   o_current_step,
    output logic                         o_cell_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD1,
        S_DIV1,
        S_LOAD2,
        S_DIV2,
        S_WALK
    } t_state;

    localparam int SW = dss_pkg::STEP_W;
    localparam int NV = dss_pkg::NUM_VOICES;

    t_state                       r_state;
    logic [dss_pkg::NUM_STEPS-1:0] r_grid [NV];
    logic [dss_pkg::SR_W-1:0]     r_sample_rate;
    logic [SW-1:0]                r_playhead;
    logic                         r_host_valid;
    logic [SW-1:0]                r_last_host;
    logic [dss_pkg::REM_W-1:0]    r_acc;

    logic [16:0]                  r_tempo;
    logic [12:0]                  r_blk;
    logic [dss_pkg::DIV_W-1:0]    r_num;
    logic [dss_pkg::REM_W-1:0]    r_period;
    logic [dss_pkg::REM_W:0]      r_sum;
    logic [SW:0]                  r_steps;
    logic [SW-1:0]                r_walk;
    logic [SW-1:0]                r_ph_final;
    logic [NV-1:0]                r_fired;

    dss_pkg::t_div_req div_req;
    dss_pkg::t_div_rsp div_rsp;

    logic [SW-1:0]                host_step;
    logic                         voice_ok;
    logic                         internal_adv;
    logic [dss_pkg::TICK_MULT_W+dss_pkg::SR_W-1:0] scaled;
    logic [dss_pkg::REM_W-1:0]    period_clamped;
    logic [SW-1:0]                walk_next;

    function automatic logic [NV-1:0] column_bits(
        input logic [dss_pkg::NUM_STEPS-1:0] grid [NV],
        input logic [SW-1:0] step
    );
        logic [NV-1:0] bits;
        for (int v = 0; v < NV; v++) begin
            bits[v] = grid[v][step];
        end
        return bits;
    endfunction

    dss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_busy       = (r_state != S_IDLE);
    assign host_step    = i_host_position[dss_pkg::TICK_SHIFT +: SW];
    assign voice_ok     = (i_voice < 4'(NV));
    assign internal_adv = (dss_pkg::t_opcode'(i_opcode) == dss_pkg::OP_ADVANCE)
                          && i_transport_playing && !i_use_host_position;
    assign scaled       = r_sample_rate * dss_pkg::TICK_MULT;
    assign walk_next    = r_walk + SW'(1);

    always_comb begin
        priority if (|div_rsp.quotient[dss_pkg::DIV_W-1:dss_pkg::REM_W]) begin
            period_clamped = '1;
        end else if (div_rsp.quotient[dss_pkg::REM_W-1:0] == '0) begin
            period_clamped = dss_pkg::REM_W'(1);
        end else begin
            period_clamped = div_rsp.quotient[dss_pkg::REM_W-1:0];
        end
    end

    always_comb begin
        div_req.load     = (r_state == S_LOAD1) || (r_state == S_LOAD2);
        div_req.dividend = (r_state == S_LOAD1) ? r_num
                                                : {{(dss_pkg::DIV_W-dss_pkg::REM_W-1){1'b0}}, r_sum};
        div_req.divisor  = (r_state == S_LOAD1) ? {15'd0, r_tempo} : r_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            for (int v = 0; v < NV; v++) begin
                r_grid[v] <= '0;
            end
            r_sample_rate  <= dss_pkg::SR_RESET;
            r_playhead     <= '0;
            r_host_valid   <= 1'b0;
            r_last_host    <= '0;
            r_acc          <= '0;
            o_valid        <= 1'b0;
            o_triggers     <= '0;
            o_current_step <= '0;
            o_cell_value   <= 1'b0;
        end else begin
            o_valid <= ((r_state == S_IDLE) && i_start && !internal_adv)
                       || ((r_state == S_WALK) && (r_steps == '0));
            if (i_cfg_we) begin
                r_sample_rate <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        unique case (dss_pkg::t_opcode'(i_opcode))
                            dss_pkg::OP_ADVANCE: begin
                                o_cell_value <= 1'b0;
                                priority if (!i_transport_playing) begin
                                    // stopped: forget host step only
                                    r_host_valid   <= 1'b0;
                                    r_last_host    <= '0;
                                    o_triggers     <= '0;
                                    o_current_step <= r_playhead;
                                end else if (i_use_host_position) begin
                                    if (!r_host_valid || host_step != r_last_host) begin
                                        r_host_valid   <= 1'b1;
                                        r_last_host    <= host_step;
                                        r_playhead     <= host_step;
                                        o_current_step <= host_step;
                                        o_triggers     <= column_bits(r_grid, host_step);
                                    end else begin
                                        o_current_step <= r_playhead;
                                        o_triggers     <= '0;
                                    end
                                end else begin
                                    r_tempo <= (i_tempo_centibpm == '0) ? 17'd1
                                                                        : i_tempo_centibpm;
                                    r_blk   <= i_block_samples;
                                    r_state <= S_MUL;
                                end
                            end
                            dss_pkg::OP_WRITE: begin
                                if (voice_ok) begin
                                    r_grid[i_voice][i_step_index] <= i_cell_on;
                                end
                                o_triggers     <= '0;
                                o_current_step <= r_playhead;
                                o_cell_value   <= 1'b0;
                            end
                            dss_pkg::OP_READ: begin
                                o_triggers     <= '0;
                                o_current_step <= r_playhead;
                                o_cell_value   <= voice_ok & r_grid[i_voice][i_step_index];
                            end
                            dss_pkg::OP_RESET: begin
                                r_acc          <= '0;
                                r_playhead     <= '0;
                                r_host_valid   <= 1'b0;
                                r_last_host    <= '0;
                                o_triggers     <= '0;
                                o_current_step <= '0;
                                o_cell_value   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_num   <= {scaled, {dss_pkg::TICK_SHIFT{1'b0}}};
                    r_state <= S_LOAD1;
                end
                S_LOAD1: begin
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_period <= period_clamped;
                        r_sum    <= {1'b0, r_acc} + {8'd0, r_blk, 12'd0};
                        r_state  <= S_LOAD2;
                    end
                end
                S_LOAD2: begin
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        r_acc      <= div_rsp.remainder;
                        // walking a full lap covers every column
                        r_steps    <= (|div_rsp.quotient[dss_pkg::DIV_W-1:SW])
                                      ? (SW+1)'(dss_pkg::NUM_STEPS)
                                      : {1'b0, div_rsp.quotient[SW-1:0]};
                        r_ph_final <= r_playhead + div_rsp.quotient[SW-1:0];
                        r_walk     <= r_playhead;
                        r_fired    <= '0;
                        r_state    <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_steps == '0) begin
                        r_playhead     <= r_ph_final;
                        o_current_step <= r_ph_final;
                        o_triggers     <= r_fired;
                        r_state        <= S_IDLE;
                    end else begin
                        r_walk  <= walk_next;
                        r_fired <= r_fired | column_bits(r_grid, walk_next);
                        r_steps <= r_steps - (SW+1)'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
